### hw/rtl/sdb_pkg.sv
// shared constants, types and a helper function for the bitmap set difference core
package sdb_pkg;

    localparam int UNIVERSE   = 4096;
    localparam int WORD_BITS  = 64;
    localparam int NWORDS     = UNIVERSE / WORD_BITS;
    localparam int MEMBER_W   = $clog2(UNIVERSE);
    localparam int WORD_W     = $clog2(WORD_BITS);
    localparam int ADDR_W     = MEMBER_W - WORD_W;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic do_update;
        logic scan_rd;
        logic scan_chk;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              drain_empty;
        logic              scan_hit;
        logic              scan_end;
        logic              out_free;
    } t_stat;

    function automatic logic [WORD_W-1:0] first_set(input logic [WORD_BITS-1:0] word);
        logic [WORD_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (word[i]) begin
                pos = WORD_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

### hw/rtl/sdb_ram.sv
// generic single-port-write, single-port-read ram with registered read
module sdb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### hw/rtl/sdb_ctrl.sv
// control state machine sequencing updates, word scans and result hand-off
module sdb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sdb_pkg::t_stat i_stat,
    output sdb_pkg::t_cmd  o_cmd
);
    import sdb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.do_update = 1'b1;
                if (i_stat.kind == KIND_DRAIN) begin
                    n_state = i_stat.drain_empty ? ST_EMIT : ST_SCAN_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_end) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sdb_dpath.sv
// datapath: membership ram, trackers, word scan and output register
module sdb_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sdb_pkg::t_cmd                   i_cmd,
    output sdb_pkg::t_stat                  o_stat,
    input  logic [sdb_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [sdb_pkg::KIND_W-1:0]      i_in_kind,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sdb_pkg::MEMBER_W-1:0]    o_out_member,
    output logic                            o_out_found,
    output logic                            o_out_ovf
);
    import sdb_pkg::*;

    localparam logic [WORD_BITS-1:0] ONE_HOT0 = {{(WORD_BITS-1){1'b0}}, 1'b1};

    logic [KIND_W-1:0]   r_kind;
    logic [VALUE_W-1:0]  r_value;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [NWORDS-1:0]   r_valid;
    logic [MEMBER_W-1:0] r_lowest;
    logic [MEMBER_W-1:0] r_highest;
    logic                r_any;
    logic [MEMBER_W-1:0] r_cursor;
    logic                r_ovf;
    logic [ADDR_W-1:0]   r_scan_w;
    logic [WORD_W-1:0]   r_scan_b;
    logic [MEMBER_W-1:0] r_res_member;
    logic                r_res_found;
    logic                r_m_valid;
    logic [MEMBER_W-1:0] r_m_member;
    logic                r_m_found;
    logic                r_m_ovf;

    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] rd_word;
    logic [ADDR_W-1:0]    raddr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;

    logic                 v_neg;
    logic                 v_big;
    logic [MEMBER_W-1:0]  v_idx;
    logic [WORD_BITS-1:0] v_onehot;
    logic                 ins_ok;
    logic                 ins_ovf;
    logic                 rem_ok;
    logic [MEMBER_W-1:0]  start;
    logic                 drain_empty;
    logic [WORD_BITS-1:0] masked;
    logic                 scan_nz;
    logic [WORD_W-1:0]    scan_pos;
    logic [MEMBER_W-1:0]  scan_idx;
    logic                 scan_hit;
    logic                 scan_end;
    logic                 out_free;

    sdb_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NWORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    // never-written words read as zero
    assign rd_word  = r_valid[r_rd_addr] ? ram_q : '0;
    assign raddr    = i_cmd.scan_rd ? r_scan_w : i_in_data[MEMBER_W-1:WORD_W];

    assign v_neg    = r_value[VALUE_W-1];
    assign v_big    = r_value[VALUE_W-2:0] >= (VALUE_W-1)'(UNIVERSE);
    assign v_idx    = r_value[MEMBER_W-1:0];
    assign v_onehot = ONE_HOT0 << v_idx[WORD_W-1:0];

    assign ins_ok   = (r_kind == KIND_INSERT) && !v_neg && !v_big;
    assign ins_ovf  = (r_kind == KIND_INSERT) && !v_neg && v_big;
    assign rem_ok   = (r_kind == KIND_REMOVE) && !v_neg && !v_big && r_any
                      && (v_idx >= r_lowest) && (v_idx <= r_highest);

    assign start       = (r_cursor > r_lowest) ? r_cursor : r_lowest;
    assign drain_empty = !r_any || (start > r_highest);

    assign masked   = rd_word & ({WORD_BITS{1'b1}} << r_scan_b);
    assign scan_nz  = |masked;
    assign scan_pos = first_set(masked);
    assign scan_idx = {r_scan_w, scan_pos};
    assign scan_hit = scan_nz && (scan_idx <= r_highest);
    assign scan_end = !scan_hit
                      && (scan_nz || (r_scan_w == r_highest[MEMBER_W-1:WORD_W]));

    assign out_free = !r_m_valid || i_out_ready;

    always_comb begin
        we    = 1'b0;
        waddr = v_idx[MEMBER_W-1:WORD_W];
        wdata = rd_word | v_onehot;
        if (i_cmd.do_update && ins_ok) begin
            we = 1'b1;
        end else if (i_cmd.do_update && rem_ok) begin
            we    = 1'b1;
            wdata = rd_word & ~v_onehot;
        end else if (i_cmd.scan_chk && scan_hit) begin
            we    = 1'b1;
            waddr = r_scan_w;
            wdata = rd_word & ~(ONE_HOT0 << scan_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= raddr;
        if (i_cmd.accept) begin
            r_kind  <= i_in_kind;
            r_value <= i_in_data[VALUE_W-1:0];
        end
        if (i_cmd.do_update && (r_kind == KIND_DRAIN)) begin
            r_scan_w     <= start[MEMBER_W-1:WORD_W];
            r_scan_b     <= start[WORD_W-1:0];
            r_res_member <= '0;
            r_res_found  <= 1'b0;
        end
        if (i_cmd.scan_chk) begin
            if (scan_hit) begin
                r_res_member <= scan_idx;
                r_res_found  <= 1'b1;
            end else if (!scan_end) begin
                r_scan_w <= r_scan_w + ADDR_W'(1);
                r_scan_b <= '0;
            end
        end
        if (i_cmd.emit_load) begin
            r_m_member <= r_res_member;
            r_m_found  <= r_res_found;
            r_m_ovf    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_lowest  <= MEMBER_W'(UNIVERSE - 1);
            r_highest <= '0;
            r_any     <= 1'b0;
            r_cursor  <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cmd.do_update && ins_ok) begin
                if (!r_any || (v_idx < r_lowest)) begin
                    r_lowest <= v_idx;
                end
                if (!r_any || (v_idx > r_highest)) begin
                    r_highest <= v_idx;
                end
                if (v_idx < r_cursor) begin
                    r_cursor <= v_idx;
                end
                r_any <= 1'b1;
            end
            if (i_cmd.do_update && ins_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.scan_chk && scan_hit) begin
                r_cursor <= (scan_idx == MEMBER_W'(UNIVERSE - 1)) ? scan_idx
                                                                  : scan_idx + MEMBER_W'(1);
            end
            if (i_cmd.emit_load) begin
                r_m_valid <= 1'b1;
                if (!r_res_found) begin
                    r_lowest  <= MEMBER_W'(UNIVERSE - 1);
                    r_highest <= '0;
                    r_any     <= 1'b0;
                    r_cursor  <= '0;
                    r_ovf     <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.drain_empty = drain_empty;
    assign o_stat.scan_hit    = scan_hit;
    assign o_stat.scan_end    = scan_end;
    assign o_stat.out_free    = out_free;

    assign o_out_valid  = r_m_valid;
    assign o_out_member = r_m_member;
    assign o_out_found  = r_m_found;
    assign o_out_ovf    = r_m_ovf;

endmodule

### hw/rtl/set_difference_bitmap_core.sv
// top level of the bitmap set difference core
// Builds A minus B over the values 0..4095 in a 64 x 64-bit membership ram. An insert
// (tuser 0) or remove (tuser 1) is a read-modify-write of one ram word; the next input
// is taken only after the write. A drain (tuser 2) returns the next remaining member in
// ascending order and clears it, scanning word by word, since each word takes one ram
// read and one check. A drain whose range is already empty goes straight to its result
// without a scan; one that scans words and finds nothing stops at the last tracked word.
// Either returns an end marker (found 0, member 0) and resets the trackers. A drain
// result is held back while the previous result stays unread. Inserts at or above 4096
// set a sticky overflow bit that comes with every drain result until the end marker.
// The result sits in an output register, so new words are taken while it waits. No
// clearing pass after reset: every ram word has a valid bit, and a word never written
// reads as empty.
module set_difference_bitmap_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sdb_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // value[31:0]
    input  logic [sdb_pkg::KIND_W-1:0]        s_axis_tuser,   // kind[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sdb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // member[11:0], overflow, zeros
    output logic [sdb_pkg::OUT_USER_W-1:0]    m_axis_tuser    // found
);
    import sdb_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [MEMBER_W-1:0] out_member;
    logic                out_found;
    logic                out_ovf;

    sdb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    sdb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_member(out_member),
        .o_out_found (out_found),
        .o_out_ovf   (out_ovf)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - MEMBER_W - 1){1'b0}}, out_ovf, out_member};
    assign m_axis_tuser = out_found;

endmodule

### hw/rtl/sdb_checker.sv
// port-level checks for the bitmap set difference core, bound to the top level
module sdb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [sdb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [sdb_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sdb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [sdb_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import sdb_pkg::*;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

    // end marker carries member zero
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[MEMBER_W-1:0] == '0)
        else $error("end marker with nonzero member");

    // a result never appears the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(in_acc))
        else $error("result produced without processing time");

    // unused pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:MEMBER_W+1] == '0)
        else $error("output pad bits not zero");

endmodule

bind set_difference_bitmap_core sdb_checker u_sdb_checker (.*);

### verif/set_difference_bitmap_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for set_difference_bitmap_core: directed and random set streams
module set_difference_bitmap_core_tb;

    import sdb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [MEMBER_W-1:0] member;
        logic                found;
        logic                overflow;
    } t_drain_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // value[31:0]
    logic [KIND_W-1:0]     s_axis_tuser  = '0;   // kind[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // member[11:0], overflow, zeros
    logic [OUT_USER_W-1:0] m_axis_tuser;         // found

    set_difference_bitmap_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // predicted set state
    bit [UNIVERSE-1:0]   member_map;
    logic [MEMBER_W-1:0] low_mark;
    logic [MEMBER_W-1:0] high_mark;
    logic [MEMBER_W-1:0] scan_pos;
    bit                  any_in;
    bit                  ovf_flag;
    t_drain_result       pending_results[$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int words_sent      = 0;
    int words_counted   = 0;
    int members_seen    = 0;
    int markers_seen    = 0;
    int overflow_seen   = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    task automatic clear_marks();
        low_mark  = MEMBER_W'(UNIVERSE - 1);
        high_mark = '0;
        scan_pos  = '0;
        any_in    = 1'b0;
        ovf_flag  = 1'b0;
    endtask

    task automatic model_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        t_drain_result res;
        int            hit_at;
        int            from;
        hit_at = -1;
        case (kind)
            KIND_INSERT: begin
                if (!value[VALUE_W-1]) begin
                    if (value >= UNIVERSE) begin
                        ovf_flag = 1'b1;
                    end else begin
                        member_map[value] = 1'b1;
                        if (!any_in || value < low_mark) low_mark = MEMBER_W'(value);
                        if (!any_in || value > high_mark) high_mark = MEMBER_W'(value);
                        if (value < scan_pos) scan_pos = MEMBER_W'(value);
                        any_in = 1'b1;
                    end
                end
            end
            KIND_REMOVE: begin
                if (!value[VALUE_W-1] && any_in
                    && value >= low_mark && value <= high_mark) begin
                    member_map[value] = 1'b0;
                end
            end
            KIND_DRAIN: begin
                if (any_in) begin
                    from = (scan_pos > low_mark) ? scan_pos : low_mark;
                    for (int i = from; i <= int'(high_mark) && hit_at < 0; i++) begin
                        if (member_map[i]) hit_at = i;
                    end
                end
                if (hit_at >= 0) begin
                    member_map[hit_at] = 1'b0;
                    scan_pos = (hit_at + 1 < UNIVERSE) ? MEMBER_W'(hit_at + 1)
                                                       : MEMBER_W'(hit_at);
                    res = '{MEMBER_W'(hit_at), 1'b1, ovf_flag};
                end else begin
                    res = '{'0, 1'b0, ovf_flag};
                    clear_marks();
                end
                pending_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_word(kind, value);
        words_sent++;
        if (kind != KIND_UNUSED && !(kind != KIND_DRAIN && value[VALUE_W-1])) words_counted++;
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // result sink and checker
    always @(posedge i_clk) begin
        t_drain_result want;
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[MEMBER_W-1:0] !== want.member)
                    report_mismatch("member", m_axis_tdata[MEMBER_W-1:0], want.member);
                if (m_axis_tuser[0] !== want.found)
                    report_mismatch("found", m_axis_tuser[0], want.found);
                if (m_axis_tdata[MEMBER_W] !== want.overflow)
                    report_mismatch("overflow", m_axis_tdata[MEMBER_W], want.overflow);
                if (want.found) members_seen++;
                else markers_seen++;
                if (want.overflow) overflow_seen++;
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** set_difference_bitmap_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_insert(input int base, input int spread);
        int r;
        r = $urandom_range(99);
        if (r < 4) return $urandom;
        if (r < 8) return {1'b1, 31'($urandom)};
        if (r < 12) return VALUE_W'(UNIVERSE + $urandom_range(0, 1000));
        return VALUE_W'((base + $urandom_range(0, spread - 1)) % UNIVERSE);
    endfunction

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_REMOVE, 32'd10);
        push_word(KIND_UNUSED, 32'hFFFF_FFFF);
        push_word(KIND_INSERT, 32'h8000_0000);
        push_word(KIND_INSERT, 32'hFFFF_FFFF);
        push_word(KIND_INSERT, 32'd4096);
        push_word(KIND_INSERT, 32'h7FFF_FFFF);
        push_word(KIND_INSERT, 32'd4095);
        push_word(KIND_INSERT, 32'd0);
        push_word(KIND_INSERT, 32'd100);
        push_word(KIND_INSERT, 32'd200);
        push_word(KIND_REMOVE, 32'hFFFF_FF9C);
        push_word(KIND_REMOVE, 32'd5000);
        push_word(KIND_REMOVE, 32'd100);
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_DRAIN,  32'hFFFF_FFFF);
        push_word(KIND_INSERT, 32'd50);
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_INSERT, 32'd4095);
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_DRAIN,  32'd0);
        push_word(KIND_DRAIN,  32'd0);
        wait_results_done();
    endtask

    // sender holds off mid-set until every drain has come back
    task automatic test_drain_pause();
        sender_idle_pct = 0;
        sink_stall_pct  = 72;
        push_word(KIND_INSERT, 32'd700);
        push_word(KIND_INSERT, 32'd1900);
        push_word(KIND_INSERT, 32'd64);
        push_word(KIND_DRAIN,  32'd0);
        wait_results_done();
        push_word(KIND_INSERT, 32'd63);
        push_word(KIND_REMOVE, 32'd1900);
        repeat (3) push_word(KIND_DRAIN, 32'd0);
        wait_results_done();
    endtask

    task automatic test_random_sets(input int budget, input int idle, input int stall);
        logic [VALUE_W-1:0] vals[$];
        logic [VALUE_W-1:0] v;
        int                 start_count;
        int                 base;
        int                 spread;
        int                 r;
        sender_idle_pct = idle;
        sink_stall_pct  = stall;
        start_count     = words_counted;
        while (words_counted - start_count < budget) begin
            if ($urandom_range(99) < 85) begin
                vals.delete();
                base   = $urandom_range(0, UNIVERSE - 1);
                spread = ($urandom_range(3) == 0) ? UNIVERSE : 128;
                repeat ($urandom_range(1, 12)) begin
                    v = pick_insert(base, spread);
                    push_word(KIND_INSERT, v);
                    vals.push_back(v);
                    if ($urandom_range(9) == 0)
                        push_word(KIND_REMOVE, vals[$urandom_range(0, vals.size() - 1)]);
                    if ($urandom_range(19) == 0) push_word(KIND_DRAIN, $urandom);
                end
                repeat ($urandom_range(0, 3)) begin
                    r = $urandom_range(9);
                    if (r < 6) v = vals[$urandom_range(0, vals.size() - 1)];
                    else if (r < 9) v = VALUE_W'((base + $urandom_range(0, spread - 1)) % UNIVERSE);
                    else v = $urandom;
                    push_word(KIND_REMOVE, v);
                end
                if ($urandom_range(15) == 0) wait_results_done();
                repeat (vals.size() + 1 + $urandom_range(0, 1)) push_word(KIND_DRAIN, $urandom);
            end else begin
                // noise and cut-short sets
                repeat ($urandom_range(1, 4)) push_word(KIND_W'($urandom_range(0, 3)), $urandom);
            end
        end
        wait_results_done();
    endtask

    initial begin
        clear_marks();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_drain_pause();
        test_random_sets(260, 0, 0);
        test_random_sets(260, 72, 0);
        test_random_sets(260, 0, 72);
        test_random_sets(260, 9, 9);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d words (%0d effective) under free-running, sender-idle,",
                 words_sent, words_counted);
        $display("sink-stall and mixed flow; checked %0d members and %0d end markers, %0d %s",
                 members_seen, markers_seen, overflow_seen, "with overflow set");
        if (mismatch_count == 0) begin
            $display("** set_difference_bitmap_core: PASSED **");
        end else begin
            $display("** set_difference_bitmap_core: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sdb_pkg.sv
hw/rtl/sdb_ram.sv
hw/rtl/sdb_ctrl.sv
hw/rtl/sdb_dpath.sv
hw/rtl/set_difference_bitmap_core.sv
hw/rtl/sdb_checker.sv
verif/set_difference_bitmap_core_tb.sv
